>>> hw/rtl/otr_pkg.sv
// Shared definitions for the overflow timer register block.
// Holds transaction codes, register selectors and the request item type.
// Depends on nothing; every other file of the block uses it.
package otr_pkg;

   // Width of the bus data path and default counter width.
   localparam int unsigned DATA_WIDTH          = 32;
   localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

   // Transaction kinds.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Register selectors.
   localparam logic [2:0] SEL_CONTROL    = 3'd0;
   localparam logic [2:0] SEL_COUNTER    = 3'd1;
   localparam logic [2:0] SEL_LOAD       = 3'd2;
   localparam logic [2:0] SEL_IRQ_ENABLE = 3'd3;
   localparam logic [2:0] SEL_IRQ_STATUS = 3'd4;

   // Bit positions in the control register.
   localparam int unsigned CTRL_START_BIT  = 0;
   localparam int unsigned CTRL_RELOAD_BIT = 1;

   // One request transaction as captured by the input register.
   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            reg_select;
      logic [DATA_WIDTH-1:0] write_data;
   } item_type;

endpackage

>>> hw/rtl/otr_in_reg.sv
// Input register of the overflow timer: captures one request transaction.
// Holds it until the core takes it. Depends on otr_pkg.
module otr_in_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [2:0]                      req_reg_select,
   input  logic [otr_pkg::DATA_WIDTH-1:0]  req_write_data,
   input  logic                            advance,
   output logic                            item_valid,
   output otr_pkg::item_type               item
);
   import otr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     load;

   // The slot is free when empty or when its transaction moves on this cycle.
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   // Next value of the slot.
   always_comb begin
      valid_in = load || (valid_ff && !advance);
      item_in  = item_ff;
      if (load) begin
         item_in.kind       = req_kind;
         item_in.reg_select = req_reg_select;
         item_in.write_data = req_write_data;
      end
   end

   // Valid flag is control state and is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/otr_core.sv
// Timer state registers, register access decode and the result register.
// Executes one transaction per cycle while the result register is not stalled. Depends on otr_pkg.
module otr_core #(
   parameter int unsigned COUNT_WIDTH = otr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  otr_pkg::item_type               item,
   output logic                            advance,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [otr_pkg::DATA_WIDTH-1:0]  rsp_read_data,
   output logic                            rsp_irq_line
);
   import otr_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
   localparam logic [COUNT_WIDTH-1:0] CountOne = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   // Timer state.
   logic                   start_ff,  start_in;
   logic                   reload_ff, reload_in;
   logic [COUNT_WIDTH-1:0] count_ff,  count_in;
   logic [COUNT_WIDTH-1:0] load_ff,   load_in;
   logic                   irq_en_ff, irq_en_in;
   logic                   flag_ff,   flag_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  read_data_ff, read_data_in;
   logic                   irq_line_ff,  irq_line_in;

   logic [COUNT_WIDTH-1:0] wdata_count;
   logic [DATA_WIDTH-1:0]  count_word;
   logic [DATA_WIDTH-1:0]  load_word;
   logic [DATA_WIDTH-1:0]  read_value;

   // Fit bus data to the counter width and counter values to the bus width.
   generate
      if (COUNT_WIDTH > DATA_WIDTH) begin : g_wide
         assign wdata_count = {{(COUNT_WIDTH-DATA_WIDTH){1'b0}}, item.write_data};
         assign count_word  = count_ff[DATA_WIDTH-1:0];
         assign load_word   = load_ff[DATA_WIDTH-1:0];
      end else if (COUNT_WIDTH == DATA_WIDTH) begin : g_equal
         assign wdata_count = item.write_data;
         assign count_word  = count_ff;
         assign load_word   = load_ff;
      end else begin : g_narrow
         assign wdata_count = item.write_data[COUNT_WIDTH-1:0];
         assign count_word  = {{(DATA_WIDTH-COUNT_WIDTH){1'b0}}, count_ff};
         assign load_word   = {{(DATA_WIDTH-COUNT_WIDTH){1'b0}}, load_ff};
      end
   endgenerate

   // A transaction executes when the result register can take its result.
   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   // Register read, register write and tick handling.
   always_comb begin
      start_in   = start_ff;
      reload_in  = reload_ff;
      count_in   = count_ff;
      load_in    = load_ff;
      irq_en_in  = irq_en_ff;
      flag_in    = flag_ff;
      read_value = '0;
      if (advance) begin
         case (item.kind)
            KIND_READ: begin
               case (item.reg_select)
                  SEL_CONTROL: begin
                     read_value[CTRL_START_BIT]  = start_ff;
                     read_value[CTRL_RELOAD_BIT] = reload_ff;
                  end
                  SEL_COUNTER:    read_value    = count_word;
                  SEL_LOAD:       read_value    = load_word;
                  SEL_IRQ_ENABLE: read_value[0] = irq_en_ff;
                  SEL_IRQ_STATUS: read_value[0] = flag_ff;
                  default:        read_value    = '0;
               endcase
            end
            KIND_WRITE: begin
               case (item.reg_select)
                  SEL_CONTROL: begin
                     start_in  = item.write_data[CTRL_START_BIT];
                     reload_in = item.write_data[CTRL_RELOAD_BIT];
                  end
                  SEL_COUNTER:    count_in  = wdata_count;
                  SEL_LOAD:       load_in   = wdata_count;
                  SEL_IRQ_ENABLE: irq_en_in = item.write_data[0];
                  SEL_IRQ_STATUS: begin
                     // Write one to clear; a zero leaves the flag alone.
                     if (item.write_data[0]) begin
                        flag_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            KIND_TICK: begin
               if (start_ff) begin
                  if (count_ff == CountMax) begin
                     flag_in = 1'b1;
                     if (reload_ff) begin
                        count_in = load_ff;
                     end else begin
                        // One-shot mode stops the timer at wrap.
                        count_in = '0;
                        start_in = 1'b0;
                     end
                  end else begin
                     count_in = count_ff + CountOne;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Result register next values.
   always_comb begin
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      read_data_in = advance ? read_value : read_data_ff;
      irq_line_in  = advance ? (flag_in && irq_en_in) : irq_line_ff;
   end

   // State and result valid are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b0;
         reload_ff    <= 1'b0;
         count_ff     <= '0;
         load_ff      <= '0;
         irq_en_ff    <= 1'b0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         load_ff      <= load_in;
         irq_en_ff    <= irq_en_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      read_data_ff <= read_data_in;
      irq_line_ff  <= irq_line_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_line  = irq_line_ff;

endmodule

>>> hw/rtl/overflow_timer_registers.sv
// Top level of the overflow timer: input register followed by the timer core.
// Depends on otr_pkg, otr_in_reg and otr_core.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | req_kind, req_reg_select, req_write_data
//   rsp     | out       | rsp_valid/rsp_stall | rsp_read_data, rsp_irq_line
//
// One transaction is accepted every cycle while the result is not stalled; the sustained rate is one per cycle.
// After acceptance a transaction is held in the input register,
// then the state update and read decode load the result register.
// Reset is synchronous and clears the timer state and both valid flags.
// A stalled result holds; the input register still fills, then req_stall rises.
module overflow_timer_registers #(
   parameter int unsigned COUNT_WIDTH = otr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [2:0]                      req_reg_select,
   input  logic [otr_pkg::DATA_WIDTH-1:0]  req_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [otr_pkg::DATA_WIDTH-1:0]  rsp_read_data,
   output logic                            rsp_irq_line
);
   import otr_pkg::*;

   logic     item_valid;
   item_type item;
   logic     advance;

   // Request capture.
   otr_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_reg_select (req_reg_select),
      .req_write_data (req_write_data),
      .advance        (advance),
      .item_valid     (item_valid),
      .item           (item)
   );

   // Timer state and result register.
   otr_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_data (rsp_read_data),
      .rsp_irq_line  (rsp_irq_line)
   );

endmodule

>>> hw/rtl/otr_checker.sv
// Port-level checks for the overflow timer, attached by a bind statement.
// Depends on overflow_timer_registers and otr_pkg.
module otr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [1:0]                      req_kind,
   input logic [2:0]                      req_reg_select,
   input logic [otr_pkg::DATA_WIDTH-1:0]  req_write_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [otr_pkg::DATA_WIDTH-1:0]  rsp_read_data,
   input logic                            rsp_irq_line
);

   // Both register stages are empty after reset.
   assert property (@(posedge clock) reset |=> !req_stall && !rsp_valid)
      else $error("stage not empty after reset");

   // With an empty result register the input register always drains.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("request stalled while result register is empty");

   // Every accepted transaction is followed by a valid result in the register.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("result missing after accepted transaction");

   // A stalled request transaction stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_kind) && $stable(req_reg_select) &&
          $stable(req_write_data)))
      else $error("stalled request changed");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_line)))
      else $error("stalled result changed");

endmodule

bind overflow_timer_registers otr_checker u_otr_checker (.*);
